FILE: rtl/core/wcr_pkg.sv
package wcr_pkg;

	// Field widths
	localparam int COORD_W  = 10;
	localparam int SAMPLE_W = 16;
	localparam int COLOR_W  = 24;
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int SPAN_W   = 6;   // holds a span of up to 63 rows
	localparam int ROW_W    = 12;  // signed working width for row arithmetic
	localparam int LVL_W    = 6;

	// Shared divider
	localparam int DIV_NUM_W  = 24;
	localparam int DIV_DEN_W  = 17;
	localparam int QUOT_W     = 8;
	localparam int DIV_STEP_W = 3;

	// Register port
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_AREA_LEFT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AREA_RIGHT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AREA_TOP    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AREA_BOTTOM = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DATA_HIGH   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DATA_LOW    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TRACE_COLOR = 3'd6;

	localparam logic [SAMPLE_W-1:0] DATA_HIGH_RST   = 16'd500;
	localparam logic [COLOR_W-1:0]  TRACE_COLOR_RST = 24'hFF0000;

	// Parameter defaults
	localparam int LINE_PAD_DEF = 1;
	localparam int MAX_SPAN_DEF = 62;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_W-1:0]    quot;
		logic [DIV_NUM_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: rtl/core/wcr_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// quot[7] set means the true quotient is 128 or more (saturated).
module wcr_div import wcr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NUM_W-1:0]  rem_q;
	logic [DIV_NUM_W-1:0]  trial;
	logic [DIV_DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [DIV_STEP_W-1:0] k_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  fits;

	assign trial = DIV_NUM_W'(den_q) << k_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.num;
				den_q  <= req.den;
				quot_q <= '0;
				k_q    <= DIV_STEP_W'(QUOT_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q       <= rem_q - trial;
					quot_q[k_q] <= 1'b1;
				end
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q && !done_q)
		else $error("divider did not start");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !quot_q[QUOT_W-1] |-> rem_q < DIV_NUM_W'(den_q))
		else $error("divider remainder not below divisor");

endmodule

FILE: rtl/core/wave_column_renderer_core.sv
// Waveform column renderer. Each input beat carries one column's max, min and mid sample;
// the block maps them onto the rows of the wave area (data_high at the top row, data_low at
// the bottom row, span limited to MAX_SPAN rows, min/max padded outward by LINE_PAD, all
// clamped to top..bottom) and emits one output beat per pixel of the vertical line at the
// sweep cursor: the mid pixel at full colour first, then pixels alternately below and above
// mid, faded towards the ends, with last_pixel set on the final beat. range_error flags a
// zero data range, in which case a single pixel is drawn on the bottom row. The cursor
// advances one column per input beat and wraps from area_right back to area_left.
// One shared 8-step restoring divider does all divisions. A column's set-up is three row
// divisions, a planning step and three colour divisions, followed by one output beat per
// emitted pixel; a column drawn as a single pixel skips the colour divisions, and a zero
// data range skips the row divisions too. in_stall stays high from acceptance until the
// last pixel has been loaded into the output register; output back-pressure only slows
// pixel emission. Registers sit on an APB-style port at byte address 4*index, pready is
// tied high, and registers must only be written while the block is idle.
module wave_column_renderer_core import wcr_pkg::*; #(
	parameter int unsigned LINE_PAD = LINE_PAD_DEF,
	parameter int unsigned MAX_SPAN = MAX_SPAN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,

	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,

	// column samples in
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] col_max,
	input  logic [SAMPLE_W-1:0] col_min,
	input  logic [SAMPLE_W-1:0] col_mid,

	// pixels out
	output logic                out_valid,
	input  logic                out_stall,
	output logic [COORD_W-1:0]  pixel_x,
	output logic [COORD_W-1:0]  pixel_y,
	output logic [COLOR_W-1:0]  pixel_color,
	output logic                range_error,
	output logic                last_pixel
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,       // span * (sample - data_low)
		S_DIVGO,     // launch row division
		S_DIVWAIT,   // wait, then scale and clamp the row
		S_PLAN,      // line extent and fade index
		S_FDIVGO,    // launch colour division
		S_FDIVWAIT,
		S_MID,       // full-colour mid pixel
		S_PIX        // faded pixels, below then above per level
	} state_t;

	// row / channel being worked on
	localparam logic [1:0] SEL_YMIN = 2'd0;   // from col_max
	localparam logic [1:0] SEL_YMAX = 2'd1;   // from col_min
	localparam logic [1:0] SEL_MID  = 2'd2;

	localparam logic signed [COORD_W:0]  MAX_SPAN_S = (COORD_W+1)'(MAX_SPAN);
	localparam logic [SPAN_W-1:0]        MAX_SPAN_V = SPAN_W'(MAX_SPAN);
	localparam logic signed [ROW_W-1:0]  PAD_S      = ROW_W'(LINE_PAD);

	// ---------------------------------------------------------------- registers
	logic [COORD_W-1:0]  area_left_q, area_right_q, area_top_q, area_bottom_q;
	logic [SAMPLE_W-1:0] data_high_q, data_low_q;
	logic [COLOR_W-1:0]  trace_color_q;

	logic                   wr_en;
	logic [REG_IDX_W-1:0]   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_left_q   <= '0;
			area_right_q  <= '0;
			area_top_q    <= '0;
			area_bottom_q <= '0;
			data_high_q   <= DATA_HIGH_RST;
			data_low_q    <= '0;
			trace_color_q <= TRACE_COLOR_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_AREA_LEFT:   area_left_q   <= pwdata[COORD_W-1:0];
				REG_AREA_RIGHT:  area_right_q  <= pwdata[COORD_W-1:0];
				REG_AREA_TOP:    area_top_q    <= pwdata[COORD_W-1:0];
				REG_AREA_BOTTOM: area_bottom_q <= pwdata[COORD_W-1:0];
				REG_DATA_HIGH:   data_high_q   <= pwdata[SAMPLE_W-1:0];
				REG_DATA_LOW:    data_low_q    <= pwdata[SAMPLE_W-1:0];
				REG_TRACE_COLOR: trace_color_q <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_AREA_LEFT:   prdata = PDATA_W'(area_left_q);
			REG_AREA_RIGHT:  prdata = PDATA_W'(area_right_q);
			REG_AREA_TOP:    prdata = PDATA_W'(area_top_q);
			REG_AREA_BOTTOM: prdata = PDATA_W'(area_bottom_q);
			REG_DATA_HIGH:   prdata = PDATA_W'(data_high_q);
			REG_DATA_LOW:    prdata = PDATA_W'(data_low_q);
			REG_TRACE_COLOR: prdata = PDATA_W'(trace_color_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- state
	state_t              state_q;
	logic [1:0]          sel_q;
	logic [COORD_W-1:0]  cursor_q, x_q, top_q, bot_q;
	logic [SPAN_W-1:0]   span_q;
	logic                err_q;
	logic [SAMPLE_W-1:0] vmax_q, vmin_q, vmid_q;
	logic [SAMPLE_W-1:0] den_mag_q;
	logic                den_neg_q;
	logic signed [DIV_NUM_W-1:0] prod_q;
	logic [COORD_W-1:0]  y_min_q, y_max_q, mid_q;
	logic [LVL_W-1:0]    index_q, a_q, b_q, m_q, lvl_q;
	logic                side_q;   // 0: below mid, 1: above mid
	logic [CHAN_W-1:0]   chq_q [NUM_CHAN];  // faded channel value of current level
	logic [LVL_W-1:0]    chr_q [NUM_CHAN];  // its remainder
	logic [CHAN_W-1:0]   cq_q  [NUM_CHAN];  // c / index
	logic [LVL_W-1:0]    cr_q  [NUM_CHAN];  // c % index

	logic                out_valid_q, range_error_q, last_pixel_q;
	logic [COORD_W-1:0]  pixel_x_q, pixel_y_q;
	logic [COLOR_W-1:0]  pixel_color_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	wcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------------- geometry at accept
	logic                  in_acc;
	logic signed [COORD_W:0] span_raw;
	logic [SPAN_W-1:0]     span_lim, span_d;
	logic [COORD_W:0]      bot_sum;
	logic [COORD_W-1:0]    bot_d, x_d, cursor_nx;
	logic signed [SAMPLE_W:0] den_d;
	logic [SAMPLE_W:0]     den_abs;
	logic                  err_d;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign span_raw = $signed({1'b0, area_bottom_q}) - $signed({1'b0, area_top_q});

	always_comb begin
		if (span_raw < 0)
			span_lim = '0;
		else if (span_raw > MAX_SPAN_S)
			span_lim = MAX_SPAN_V;
		else
			span_lim = span_raw[SPAN_W-1:0];
	end

	assign bot_sum = {1'b0, area_top_q} + (COORD_W+1)'(span_lim);
	assign bot_d   = bot_sum[COORD_W] ? '1 : bot_sum[COORD_W-1:0];
	assign span_d  = SPAN_W'(bot_d - area_top_q);

	assign den_d   = $signed({data_high_q[SAMPLE_W-1], data_high_q})
		- $signed({data_low_q[SAMPLE_W-1], data_low_q});
	assign den_abs = den_d[SAMPLE_W] ? (SAMPLE_W+1)'(-den_d) : (SAMPLE_W+1)'(den_d);
	assign err_d   = (data_high_q == data_low_q);

	// a cursor past area_right is brought back to area_left before drawing; it advances after it
	assign x_d       = (cursor_q > area_right_q) ? area_left_q : cursor_q;
	assign cursor_nx = (x_d == '1) ? area_left_q : x_d + 1'b1;

	// ---------------------------------------------------------------- row scaling
	logic [SAMPLE_W-1:0]      v_sel;
	logic signed [SAMPLE_W:0] diff;
	logic signed [DIV_NUM_W-1:0] prod_d;
	logic [DIV_NUM_W-1:0]     prod_mag;
	logic                     q_neg;
	logic signed [ROW_W-1:0]  q_s, base, row_raw;
	logic [COORD_W-1:0]       row_d;

	always_comb begin
		case (sel_q)
			SEL_YMIN: v_sel = vmax_q;
			SEL_YMAX: v_sel = vmin_q;
			default:  v_sel = vmid_q;
		endcase
	end

	assign diff   = $signed({v_sel[SAMPLE_W-1], v_sel})
		- $signed({data_low_q[SAMPLE_W-1], data_low_q});
	assign prod_d = $signed({1'b0, span_q}) * diff;

	assign prod_mag = prod_q[DIV_NUM_W-1] ? DIV_NUM_W'(-prod_q) : DIV_NUM_W'(prod_q);
	assign q_neg    = prod_q[DIV_NUM_W-1] ^ den_neg_q;   // division truncates toward zero
	assign q_s      = q_neg ? -$signed({4'b0, div_rsp.quot}) : $signed({4'b0, div_rsp.quot});
	assign base     = $signed({2'b0, bot_q});

	always_comb begin
		case (sel_q)
			SEL_YMIN: row_raw = base - PAD_S - q_s;
			SEL_YMAX: row_raw = base + PAD_S - q_s;
			default:  row_raw = base - q_s;
		endcase
	end

	// a saturated quotient (128+) always lands outside top..bottom, so clamping fixes it
	always_comb begin
		if (row_raw > base)
			row_d = bot_q;
		else if (row_raw < $signed({2'b0, top_q}))
			row_d = top_q;
		else
			row_d = row_raw[COORD_W-1:0];
	end

	// ---------------------------------------------------------------- line plan
	logic signed [COORD_W:0] dy, da, db;
	logic [LVL_W-1:0]        k_d, index_d, a_d, b_d, m_d;

	assign dy      = $signed({1'b0, y_max_q}) - $signed({1'b0, y_min_q});
	assign da      = $signed({1'b0, mid_q}) - $signed({1'b0, y_min_q});
	assign db      = $signed({1'b0, y_max_q}) - $signed({1'b0, mid_q});
	assign k_d     = LVL_W'(dy[SPAN_W-1:1]) + LVL_W'(1);
	assign index_d = LVL_W'(dy[SPAN_W-1:1]) + LVL_W'(2);

	// a: pixels above mid, b: pixels below mid, both capped at (dy>>1)+1
	always_comb begin
		if (dy < 1 || da < 1)
			a_d = '0;
		else if (da > $signed({{(COORD_W+1-LVL_W){1'b0}}, k_d}))
			a_d = k_d;
		else
			a_d = da[LVL_W-1:0];
		if (dy < 1 || db < 1)
			b_d = '0;
		else if (db > $signed({{(COORD_W+1-LVL_W){1'b0}}, k_d}))
			b_d = k_d;
		else
			b_d = db[LVL_W-1:0];
	end

	assign m_d = (a_d > b_d) ? a_d : b_d;

	// ---------------------------------------------------------------- fade
	logic [CHAN_W-1:0]      chan_sel;
	logic signed [LVL_W:0]  rdiff  [NUM_CHAN];
	logic [CHAN_W-1:0]      chq_nx [NUM_CHAN];
	logic [LVL_W-1:0]       chr_nx [NUM_CHAN];

	always_comb begin
		case (sel_q)
			SEL_YMIN: chan_sel = trace_color_q[23:16];
			SEL_YMAX: chan_sel = trace_color_q[15:8];
			default:  chan_sel = trace_color_q[7:0];
		endcase
	end

	// one level down: numerator drops by c = cq*index + cr, at most one borrow
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			rdiff[c] = $signed({1'b0, chr_q[c]}) - $signed({1'b0, cr_q[c]});
			if (rdiff[c] < 0) begin
				chr_nx[c] = LVL_W'(rdiff[c] + $signed({1'b0, index_q}));
				chq_nx[c] = chq_q[c] - cq_q[c] - 1'b1;
			end else begin
				chr_nx[c] = rdiff[c][LVL_W-1:0];
				chq_nx[c] = chq_q[c] - cq_q[c];
			end
		end
	end

	always_comb begin
		div_req.start = (state_q == S_DIVGO) || (state_q == S_FDIVGO);
		if (state_q == S_FDIVGO) begin
			div_req.num = DIV_NUM_W'(chan_sel);
			div_req.den = DIV_DEN_W'(index_q);
		end else begin
			div_req.num = prod_mag;
			div_req.den = DIV_DEN_W'(den_mag_q);
		end
	end

	// ---------------------------------------------------------------- emission
	logic               out_free;
	logic               pix_load;
	logic [COORD_W-1:0] cur_row;
	logic               cur_last;
	logic [LVL_W-1:0]   lvl_nx;

	assign out_free = !out_valid_q || !out_stall;
	// a pixel beat is loaded into the output register this cycle
	assign pix_load = ((state_q == S_MID) || (state_q == S_PIX)) && out_free;
	assign cur_row  = side_q ? mid_q - COORD_W'(lvl_q) : mid_q + COORD_W'(lvl_q);
	// last beat: top level, and the above pixel unless that side ran out earlier
	assign cur_last = (lvl_q == m_q) && (side_q || (a_q < m_q));
	assign lvl_nx   = lvl_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sel_q         <= SEL_YMIN;
			cursor_q      <= '0;
			x_q           <= '0;
			top_q         <= '0;
			bot_q         <= '0;
			span_q        <= '0;
			err_q         <= 1'b0;
			vmax_q        <= '0;
			vmin_q        <= '0;
			vmid_q        <= '0;
			den_mag_q     <= '0;
			den_neg_q     <= 1'b0;
			prod_q        <= '0;
			y_min_q       <= '0;
			y_max_q       <= '0;
			mid_q         <= '0;
			index_q       <= '0;
			a_q           <= '0;
			b_q           <= '0;
			m_q           <= '0;
			lvl_q         <= '0;
			side_q        <= 1'b0;
			for (int c = 0; c < NUM_CHAN; c++) begin
				chq_q[c] <= '0;
				chr_q[c] <= '0;
				cq_q[c]  <= '0;
				cr_q[c]  <= '0;
			end
			out_valid_q   <= 1'b0;
			pixel_x_q     <= '0;
			pixel_y_q     <= '0;
			pixel_color_q <= '0;
			range_error_q <= 1'b0;
			last_pixel_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !pix_load)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						vmax_q    <= col_max;
						vmin_q    <= col_min;
						vmid_q    <= col_mid;
						x_q       <= x_d;
						cursor_q  <= cursor_nx;
						top_q     <= area_top_q;
						bot_q     <= bot_d;
						span_q    <= span_d;
						err_q     <= err_d;
						den_mag_q <= den_abs[SAMPLE_W-1:0];
						den_neg_q <= den_d[SAMPLE_W];
						// zero data range: every row is the bottom row
						y_min_q   <= bot_d;
						y_max_q   <= bot_d;
						mid_q     <= bot_d;
						sel_q     <= SEL_YMIN;
						state_q   <= err_d ? S_PLAN : S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod_d;
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIVWAIT;
				end
				S_DIVWAIT: begin
					if (div_rsp.done) begin
						case (sel_q)
							SEL_YMIN: y_min_q <= row_d;
							SEL_YMAX: y_max_q <= row_d;
							default:  mid_q   <= row_d;
						endcase
						if (sel_q == SEL_MID) begin
							state_q <= S_PLAN;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_PLAN: begin
					index_q <= index_d;
					a_q     <= a_d;
					b_q     <= b_d;
					m_q     <= m_d;
					for (int c = 0; c < NUM_CHAN; c++) begin
						chq_q[c] <= trace_color_q[COLOR_W-CHAN_W*(c+1) +: CHAN_W];
						chr_q[c] <= '0;
					end
					sel_q   <= SEL_YMIN;
					state_q <= (m_d == '0) ? S_MID : S_FDIVGO;
				end
				S_FDIVGO: begin
					state_q <= S_FDIVWAIT;
				end
				S_FDIVWAIT: begin
					if (div_rsp.done) begin
						cq_q[sel_q] <= div_rsp.quot;
						cr_q[sel_q] <= div_rsp.rem[LVL_W-1:0];
						if (sel_q == SEL_MID) begin
							state_q <= S_MID;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= S_FDIVGO;
						end
					end
				end
				S_MID: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						pixel_x_q     <= x_q;
						pixel_y_q     <= mid_q;
						pixel_color_q <= trace_color_q;
						range_error_q <= err_q;
						last_pixel_q  <= (m_q == '0);
						if (m_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							for (int c = 0; c < NUM_CHAN; c++) begin
								chq_q[c] <= chq_nx[c];
								chr_q[c] <= chr_nx[c];
							end
							lvl_q   <= LVL_W'(1);
							side_q  <= (b_q == '0);
							state_q <= S_PIX;
						end
					end
				end
				S_PIX: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						pixel_x_q     <= x_q;
						pixel_y_q     <= cur_row;
						pixel_color_q <= {chq_q[0], chq_q[1], chq_q[2]};
						range_error_q <= err_q;
						last_pixel_q  <= cur_last;
						if (cur_last) begin
							state_q <= S_IDLE;
						end else if (!side_q && (lvl_q <= a_q)) begin
							side_q <= 1'b1;
						end else begin
							lvl_q  <= lvl_nx;
							side_q <= !(lvl_nx <= b_q);
							for (int c = 0; c < NUM_CHAN; c++) begin
								chq_q[c] <= chq_nx[c];
								chr_q[c] <= chr_nx[c];
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign range_error = range_error_q;
	assign last_pixel  = last_pixel_q;

	// ---------------------------------------------------------------- checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted column did not start work");

	a_row_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_pixel_q |-> pixel_y_q >= top_q && pixel_y_q <= bot_q)
		else $error("pixel row outside wave area");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_pixel_q |-> in_stall)
		else $error("new column taken before previous line finished");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PIX |-> lvl_q >= LVL_W'(1) && lvl_q <= m_q)
		else $error("fade level out of range");

endmodule
